// ===== rtl/core/sortk_pkg.sv =====
// Package for the sorted top-k record table.
// Holds sizes, the command codes and the transaction and cell structs.
// No dependencies.
package sortk_pkg;

    // Table depth and derived widths
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    // Common width for position / count compares (ENTRIES is at most 64)
    localparam int CMP_W   = 8;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_CHECK  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // One stored record
    typedef struct packed {
        logic signed [31:0] score;
        logic [15:0]        level;
        logic [23:0]        kills;
        logic [31:0]        time_bits;
        logic [4:0]         day;
        logic [3:0]         month;
        logic [11:0]        year;
    } t_record;

    // Input transaction
    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] score;
        logic [15:0]        level;
        logic [23:0]        kills;
        logic [31:0]        time_bits;
        logic [4:0]         day;
        logic [3:0]         month;
        logic [11:0]        year;
        logic [3:0]         position;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic               accepted;
        logic [3:0]         slot;
        logic [4:0]         entry_count;
        logic signed [31:0] top_score;
        logic signed [31:0] lowest_score;
        logic signed [31:0] entry_score;
        logic [15:0]        entry_level;
        logic [23:0]        entry_kills;
        logic [31:0]        entry_time_bits;
        logic [4:0]         entry_day;
        logic [3:0]         entry_month;
        logic [11:0]        entry_year;
    } t_out;

    // Control into one cell
    typedef struct packed {
        logic we;      // insert transaction this cycle
        logic valid;   // cell holds a live record
        logic q_left;  // left neighbour qualifies
    } t_cell_ctl;

    // Status out of one cell
    typedef struct packed {
        logic qual;    // new score goes at or before this cell
        logic load;    // cell takes the new record
    } t_cell_stat;

endpackage

// ===== rtl/core/sortk_cell.sv =====
// One position of the sorted table: holds a record, compares the incoming
// score against it and either keeps, loads the new record or shifts from the left.
// Depends on sortk_pkg.
module sortk_cell (
    input  logic                   i_clk,
    input  sortk_pkg::t_cell_ctl   i_ctl,
    input  sortk_pkg::t_record     i_new,
    input  sortk_pkg::t_record     i_left,
    output sortk_pkg::t_record     o_rec,
    output sortk_pkg::t_cell_stat  o_stat
);
    import sortk_pkg::*;

    t_record r_rec;
    t_record n_rec;
    logic    qual;
    logic    load;
    logic    shift;

    // Empty cells always qualify; strict compare keeps ties after older ones
    assign qual  = !i_ctl.valid || (i_new.score > r_rec.score);
    assign load  = qual && !i_ctl.q_left;
    assign shift = i_ctl.q_left;

    always_comb begin
        n_rec = r_rec;
        if (i_ctl.we && shift) begin
            n_rec = i_left;
        end else if (i_ctl.we && load) begin
            n_rec = i_new;
        end
    end

    // Record storage, no reset: liveness comes from the count
    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec       = r_rec;
    assign o_stat.qual = qual;
    assign o_stat.load = load;

endmodule

// ===== rtl/core/sorted_top_k_insert_unit.sv =====
// Sorted top-k record table built as a chain of compare/shift cells.
// Result strobe o_done is registered and rises in the cycle after the accepting edge.
// Throughput: one transaction per cycle; busy is never raised, every cell
// compares and shifts in the same cycle. The receiver cannot stall.
// Reset (synchronous, active low) empties the table and drops the strobe;
// record contents are not cleared. Depends on sortk_pkg and sortk_cell.
module sorted_top_k_insert_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  sortk_pkg::t_in   i_item,
    output logic             o_done,
    output sortk_pkg::t_out  o_result
);
    import sortk_pkg::*;

    t_record    cell_rec  [ENTRIES];
    t_cell_stat cell_stat [ENTRIES];
    t_cell_ctl  cell_ctl  [ENTRIES];
    t_record    new_rec;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    logic             r_accepted;
    logic             n_accepted;
    logic [3:0]       r_slot;
    logic [3:0]       n_slot;
    t_record          r_entry;
    t_record          n_entry;

    logic             go;
    logic             full;
    logic             found;
    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] slot_x;
    logic             rd_ok;
    t_record          rd_rec;

    assign busy = 1'b0;
    assign go   = start && !busy;

    assign new_rec.score     = i_item.score;
    assign new_rec.level     = i_item.level;
    assign new_rec.kills     = i_item.kills;
    assign new_rec.time_bits = i_item.time_bits;
    assign new_rec.day       = i_item.day;
    assign new_rec.month     = i_item.month;
    assign new_rec.year      = i_item.year;

    assign cnt_x = {{(CMP_W-CNT_W){1'b0}}, r_count};
    assign pos_x = {{(CMP_W-4){1'b0}}, i_item.position};
    assign full  = (cnt_x == CMP_W'(ENTRIES));

    // Cell chain
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        assign cell_ctl[g].we    = go && (i_item.cmd == CMD_INSERT);
        assign cell_ctl[g].valid = (CMP_W'(g) < cnt_x);
        if (g == 0) begin : g_head
            assign cell_ctl[g].q_left = 1'b0;
            sortk_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (cell_ctl[g]),
                .i_new  (new_rec),
                .i_left (new_rec),
                .o_rec  (cell_rec[g]),
                .o_stat (cell_stat[g])
            );
        end else begin : g_body
            assign cell_ctl[g].q_left = cell_stat[g-1].qual;
            sortk_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (cell_ctl[g]),
                .i_new  (new_rec),
                .i_left (cell_rec[g-1]),
                .o_rec  (cell_rec[g]),
                .o_stat (cell_stat[g])
            );
        end
    end

    // Qualify flags are monotone along the chain, so the tail says it all
    assign found = cell_stat[ENTRIES-1].qual;

    // Slot encode from the one-hot load flags
    always_comb begin
        slot_x = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (cell_stat[i].load) begin
                slot_x = slot_x | CMP_W'(i);
            end
        end
    end

    // Read selection
    assign rd_ok = (pos_x < cnt_x) && (pos_x < CMP_W'(ENTRIES));
    always_comb begin
        rd_rec = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (pos_x == CMP_W'(i)) begin
                rd_rec = cell_rec[i];
            end
        end
    end

    // Next count and result fields
    always_comb begin
        n_count    = r_count;
        n_accepted = 1'b0;
        n_slot     = '0;
        n_entry    = '0;
        case (i_item.cmd)
            CMD_INSERT: begin
                if (found) begin
                    n_accepted = 1'b1;
                    n_slot     = slot_x[3:0];
                    if (!full) begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            CMD_CHECK: begin
                n_accepted = found;
            end
            CMD_READ: begin
                if (rd_ok) begin
                    n_accepted = 1'b1;
                    n_entry    = rd_rec;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= go;
            if (go) begin
                r_count <= n_count;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_accepted <= n_accepted;
            r_slot     <= n_slot;
            r_entry    <= n_entry;
        end
    end

    // Table summary comes straight from the live state
    assign o_done                   = r_done;
    assign o_result.accepted        = r_accepted;
    assign o_result.slot            = r_slot;
    assign o_result.entry_count     = cnt_x[4:0];
    assign o_result.top_score       = (r_count == '0) ? 32'sd0 : cell_rec[0].score;
    assign o_result.lowest_score    = full ? cell_rec[ENTRIES-1].score : -32'sd1;
    assign o_result.entry_score     = r_entry.score;
    assign o_result.entry_level     = r_entry.level;
    assign o_result.entry_kills     = r_entry.kills;
    assign o_result.entry_time_bits = r_entry.time_bits;
    assign o_result.entry_day       = r_entry.day;
    assign o_result.entry_month     = r_entry.month;
    assign o_result.entry_year      = r_entry.year;

endmodule

// ===== dv/sorted_top_k_insert_unit_checker.sv =====
// Checker for the sorted top-k record table: watches the command and result
// channels, predicts each result and compares it field by field.
// Depends on sortk_pkg.
`timescale 1ns / 1ps

module sorted_top_k_insert_unit_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  sortk_pkg::t_in    i_item,
    input  logic              i_done,
    input  sortk_pkg::t_out   i_result,
    output int                o_fail_count,
    output int                o_pending
);
    import sortk_pkg::*;

    // Predicted table contents and the results still owed by the block
    t_record rec_table [ENTRIES];
    int      rec_count;
    t_out    result_q [$];

    // Apply one transaction to the predicted table and return its result
    function automatic t_out apply_cmd(input t_in it);
        t_out    res;
        t_record rec;
        int      at;
        bit      found;
        res   = '0;
        at    = ENTRIES;
        found = 1'b0;
        case (it.cmd)
            CMD_INSERT: begin
                // first stored score strictly beaten; ties go behind
                for (int i = 0; i < rec_count; i++) begin
                    if (!found && ($signed(it.score) > $signed(rec_table[i].score))) begin
                        at    = i;
                        found = 1'b1;
                    end
                end
                if (!found && rec_count < ENTRIES) begin
                    at    = rec_count;
                    found = 1'b1;
                end
                if (found) begin
                    for (int i = ENTRIES - 1; i > at; i--)
                        rec_table[i] = rec_table[i - 1];
                    rec.score     = it.score;
                    rec.level     = it.level;
                    rec.kills     = it.kills;
                    rec.time_bits = it.time_bits;
                    rec.day       = it.day;
                    rec.month     = it.month;
                    rec.year      = it.year;
                    rec_table[at] = rec;
                    if (rec_count < ENTRIES)
                        rec_count++;
                    res.accepted = 1'b1;
                    res.slot     = 4'(at);
                end
            end
            CMD_CHECK: begin
                res.accepted = (rec_count < ENTRIES) ||
                    ($signed(it.score) > $signed(rec_table[ENTRIES - 1].score));
            end
            CMD_READ: begin
                if (int'(it.position) < rec_count) begin
                    res.accepted        = 1'b1;
                    res.entry_score     = rec_table[it.position].score;
                    res.entry_level     = rec_table[it.position].level;
                    res.entry_kills     = rec_table[it.position].kills;
                    res.entry_time_bits = rec_table[it.position].time_bits;
                    res.entry_day       = rec_table[it.position].day;
                    res.entry_month     = rec_table[it.position].month;
                    res.entry_year      = rec_table[it.position].year;
                end
            end
            default: begin
                rec_count = 0;
            end
        endcase
        res.entry_count  = 5'(rec_count);
        res.top_score    = (rec_count == 0) ? 32'sd0 : rec_table[0].score;
        res.lowest_score = (rec_count < ENTRIES) ? -32'sd1 : rec_table[ENTRIES - 1].score;
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    // Predict on every accepted transaction, compare on every strobe
    always @(posedge i_clk) begin : monitor
        t_out want;
        if (!i_rst_n) begin
            o_fail_count = 0;
            rec_count    = 0;
            foreach (rec_table[i])
                rec_table[i] = '0;
            result_q.delete();
        end else begin
            if (i_start && !i_busy)
                result_q.push_back(apply_cmd(i_item));
            if (i_done) begin
                if (result_q.size() == 0) begin
                    $error("result strobe with no transaction outstanding");
                    o_fail_count++;
                end else begin
                    want = result_q.pop_front();
                    compare_field("accepted", 32'(want.accepted),
                                  32'(i_result.accepted));
                    compare_field("slot", 32'(want.slot), 32'(i_result.slot));
                    compare_field("entry_count", 32'(want.entry_count),
                                  32'(i_result.entry_count));
                    compare_field("top_score", want.top_score, i_result.top_score);
                    compare_field("lowest_score", want.lowest_score, i_result.lowest_score);
                    compare_field("entry_score", want.entry_score, i_result.entry_score);
                    compare_field("entry_level", 32'(want.entry_level),
                                  32'(i_result.entry_level));
                    compare_field("entry_kills", 32'(want.entry_kills),
                                  32'(i_result.entry_kills));
                    compare_field("entry_time_bits", want.entry_time_bits,
                                  i_result.entry_time_bits);
                    compare_field("entry_day", 32'(want.entry_day),
                                  32'(i_result.entry_day));
                    compare_field("entry_month", 32'(want.entry_month),
                                  32'(i_result.entry_month));
                    compare_field("entry_year", 32'(want.entry_year),
                                  32'(i_result.entry_year));
                end
            end
        end
        o_pending <= result_q.size();
    end

endmodule

// ===== dv/sorted_top_k_insert_unit_tb.sv =====
// Testbench top for the sorted top-k record table: clock, reset, directed and
// random command stimulus, stall watchdog and verdict.
// Depends on sortk_pkg, sorted_top_k_insert_unit and the checker module.
`timescale 1ns / 1ps

module sorted_top_k_insert_unit_tb;
    import sortk_pkg::*;

    localparam int STALL_LIMIT   = 200;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_LEN     = 100;
    localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] SCORE_MAX = 32'sh7FFF_FFFF;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic o_done;
    t_in  i_item;
    t_out o_result;
    int   fail_count;
    int   pending;
    int   stall_cycles;
    bit   no_idle;

    sorted_top_k_insert_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    sorted_top_k_insert_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Watchdog: too long without any transaction moving ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("sorted_top_k_insert_unit_tb NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Score draw: tight range for ties, full range, extremes, or mid range
    function automatic logic signed [31:0] draw_score(input int mode);
        int v;
        case (mode)
            0: begin
                v = $urandom_range(0, 15);
                return v - 8;
            end
            1: return $urandom;
            2: begin
                case ($urandom_range(0, 5))
                    0: return SCORE_MIN;
                    1: return SCORE_MIN + 1;
                    2: return SCORE_MAX;
                    3: return SCORE_MAX - 1;
                    4: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: begin
                v = $urandom_range(0, 1000);
                return v - 500;
            end
        endcase
    endfunction

    // Command with random record fields and position
    function automatic t_in random_fields(input t_cmd op, input logic signed [31:0] s);
        t_in it;
        it.cmd       = op;
        it.score     = s;
        it.level     = 16'($urandom);
        it.kills     = 24'($urandom);
        it.time_bits = $urandom;
        it.day       = 5'($urandom);
        it.month     = 4'($urandom);
        it.year      = 12'($urandom);
        it.position  = 4'($urandom);
        return it;
    endfunction

    // Present one transaction after a random gap (none when no_idle is set) and wait for acceptance
    task automatic issue(input t_in it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        t_in  it;
        t_cmd op;
        int   mode;
        int   clear_pct;
        int   r;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        no_idle = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, extreme records, ties, full table, clear
        issue(random_fields(CMD_CLEAR, 32'sd0));
        it = random_fields(CMD_READ, 32'sd0);
        it.position = 4'd0;
        issue(it);
        issue(random_fields(CMD_CHECK, SCORE_MIN));
        it = '1;
        it.cmd   = CMD_INSERT;
        it.score = SCORE_MAX;
        issue(it);
        it = '0;
        it.cmd   = CMD_INSERT;
        it.score = SCORE_MIN;
        issue(it);
        // equal to the top score, so it lands behind the older record
        issue(random_fields(CMD_INSERT, SCORE_MAX));
        for (int p = 0; p < 3; p++) begin
            it = random_fields(CMD_READ, 32'sd0);
            it.position = 4'(p);
            issue(it);
        end
        it.position = 4'd15;
        issue(it);
        repeat (13) issue(random_fields(CMD_INSERT, draw_score(1)));
        // table now full: tie with the lowest is rejected, anything above qualifies
        issue(random_fields(CMD_INSERT, SCORE_MIN));
        issue(random_fields(CMD_CHECK, SCORE_MIN));
        issue(random_fields(CMD_CHECK, SCORE_MIN + 1));
        issue(random_fields(CMD_INSERT, SCORE_MAX));
        it = random_fields(CMD_READ, 32'sd0);
        it.position = 4'd15;
        issue(it);
        issue(random_fields(CMD_CLEAR, 32'sd0));

        // Random phases: score style, clear rate and idling vary per phase
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            mode      = $urandom_range(0, 3);
            clear_pct = $urandom_range(0, 1) ? 1 : 6;
            no_idle   = ($urandom_range(0, 3) == 0);
            repeat (PHASE_LEN) begin
                r = $urandom_range(0, 99);
                if (r < clear_pct)
                    op = CMD_CLEAR;
                else if (r < 55)
                    op = CMD_INSERT;
                else if (r < 70)
                    op = CMD_CHECK;
                else
                    op = CMD_READ;
                issue(random_fields(op, ($urandom_range(0, 9) == 0) ? draw_score(2)
                                                                   : draw_score(mode)));
            end
        end
        start <= 1'b0;

        // Drain outstanding results, then a short settle
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("sorted_top_k_insert_unit_tb OK");
        else
            $display("sorted_top_k_insert_unit_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/sortk_pkg.sv
rtl/core/sortk_cell.sv
rtl/core/sorted_top_k_insert_unit.sv
dv/sorted_top_k_insert_unit_checker.sv
dv/sorted_top_k_insert_unit_tb.sv
